// ===== sv/gradient_ramp_color_core_assert.svh =====
// ----------------------------------------------------------------------------
// Gradient ramp colour core assertion macros
// Concurrent property shorthands clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_RAMP_COLOR_CORE_ASSERT_SVH
`define GRADIENT_RAMP_COLOR_CORE_ASSERT_SVH

// same-cycle implication
`define GRC_AST_IMP(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("grc property violated");

// next-cycle implication
`define GRC_AST_NXT(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("grc property violated");

`endif

// ===== sv/grc_pkg.sv =====
// ----------------------------------------------------------------------------
// grc_pkg
// Shared constants, types and helpers of the gradient ramp colour core.
// ----------------------------------------------------------------------------
package grc_pkg;

  localparam int MAX_STOPS_DEF  = 16;
  localparam int COORD_BITS_DEF = 16;
  localparam int OFFW           = 17;
  localparam int COLW           = 32;
  localparam logic [OFFW-1:0] OFFSET_ONE = 17'h10000;

  localparam int GRAD_START_RST  = 0;
  localparam int GRAD_END_RST    = 256;
  localparam int STOP_COUNT_RST  = 1;
  localparam int LINE_LENGTH_RST = 256;

  typedef enum logic [2:0] {
    REG_GRAD_START  = 3'd0,
    REG_GRAD_END    = 3'd1,
    REG_SPREAD_MODE = 3'd2,
    REG_STOP_COUNT  = 3'd3,
    REG_LINE_LENGTH = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SPREAD_PAD     = 2'd0,
    SPREAD_REFLECT = 2'd1,
    SPREAD_REPEAT  = 2'd2
  } spread_t;

  typedef enum logic [0:0] {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_MODW,
    ST_CLASS,
    ST_FETCH,
    ST_FETCH_D,
    ST_RD,
    ST_EFF,
    ST_SEG,
    ST_IMUL,
    ST_IDIV,
    ST_IDIVW,
    ST_DONE
  } grc_state_t;

  function automatic int max_i(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // byte j of an RGBA word, red first
  function automatic logic [7:0] chan(input logic [COLW-1:0] c, input logic [1:0] j);
    logic [7:0] r;
    unique case (j)
      2'd0: r = c[31:24];
      2'd1: r = c[23:16];
      2'd2: r = c[15:8];
      default: r = c[7:0];
    endcase
    return r;
  endfunction

endpackage

// ===== sv/grc_div.sv =====
// ----------------------------------------------------------------------------
// grc_div
// Restoring divider, one quotient bit per cycle against a pre-shifted divisor.
// ----------------------------------------------------------------------------
module grc_div #(
  parameter int UW  = 41,
  parameter int QW  = 16,
  parameter int STW = 5
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [UW-1:0]  dividend,
  input  logic [UW-1:0]  divisor,
  input  logic [STW-1:0] steps,
  output logic           done,
  output logic [QW-1:0]  quot,
  output logic [UW-1:0]  rem
);

  logic           busy_r;
  logic           done_r;
  logic [UW-1:0]  rem_r;
  logic [UW-1:0]  sh_r;
  logic [QW-1:0]  q_r;
  logic [STW-1:0] cnt_r;
  logic           ge;

  assign ge = rem_r >= sh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == STW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      sh_r  <= divisor;
      q_r   <= '0;
      cnt_r <= steps;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - sh_r;
      end
      q_r   <= {q_r[QW-2:0], ge};
      sh_r  <= sh_r >> 1;
      cnt_r <= cnt_r - STW'(1);
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

// ===== sv/gradient_ramp_color_core.sv =====
// Sequence: a stop load is written straight into the stop table; an outside query
// goes directly to the done state. An inside query walks the stops and, when it lands in a segment,
// interpolates (4 channels of multiply plus an 8-step divide); reflect/repeat first
// run a modulo on the shared divider.
// One query in flight; the next is taken once the result sits in the output register.
// Reset: synchronous, clears control and loads register defaults; stop table undefined.
// ----------------------------------------------------------------------------
// gradient_ramp_color_core
// Gradient stop table and per-pixel colour ramp with pad, reflect and repeat.
// ----------------------------------------------------------------------------
module gradient_ramp_color_core #(
  parameter int MAX_STOPS  = grc_pkg::MAX_STOPS_DEF,
  parameter int COORD_BITS = grc_pkg::COORD_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         cfg_valid,
  output logic                                         cfg_ready,
  input  logic [2:0]                                   cfg_addr,
  input  logic [grc_pkg::max_i(COORD_BITS, 16)-1:0]    cfg_data,
  input  logic                                         in_valid,
  output logic                                         in_stall,
  input  logic                                         in_req_type,
  input  logic [3:0]                                   in_stop_index,
  input  logic [16:0]                                  in_stop_offset,
  input  logic [7:0]                                   in_stop_red,
  input  logic [7:0]                                   in_stop_green,
  input  logic [7:0]                                   in_stop_blue,
  input  logic [7:0]                                   in_stop_alpha,
  input  logic signed [COORD_BITS-1:0]                 in_position,
  output logic                                         out_valid,
  input  logic                                         out_stall,
  output logic [7:0]                                   out_red,
  output logic [7:0]                                   out_green,
  output logic [7:0]                                   out_blue,
  output logic [7:0]                                   out_alpha,
  output logic                                         out_outside
);

  localparam int CW   = COORD_BITS;
  localparam int DW   = CW + 1;
  localparam int LW   = CW + 1;
  localparam int OFFW = grc_pkg::OFFW;
  localparam int COLW = grc_pkg::COLW;
  localparam int MW   = OFFW + COLW;
  localparam int SW   = $clog2(MAX_STOPS);
  localparam int NW   = $clog2(MAX_STOPS + 1);
  localparam int MAW  = grc_pkg::max_i(OFFW, LW);
  localparam int MBW  = LW;
  localparam int PW   = MAW + MBW;
  localparam int DENW = OFFW + LW;
  localparam int NUMW = LW + 8;
  localparam int UW   = grc_pkg::max_i(NUMW + 16, 2 * CW + 1);
  localparam int XW   = grc_pkg::max_i(CW, 16);
  localparam int STW  = $clog2(CW + 1);

  grc_pkg::grc_state_t state_r, state_nxt;

  logic signed [CW-1:0] grad_start_r, grad_end_r;
  logic [1:0]           spread_r;
  logic [4:0]           stop_count_r;
  logic [15:0]          line_length_r;

  logic [MW-1:0]   mem [MAX_STOPS];
  logic [MW-1:0]   rd_q_r;

  logic [LW-1:0]        len_r;
  logic signed [DW-1:0] d_r;
  logic [NW-1:0]        n_r;
  logic [SW-1:0]        k_r;
  logic [LW-1:0]        pos_r;
  logic [OFFW-1:0]      prev_eff_r;
  logic [COLW-1:0]      cur_col_r, prev_col_r;
  logic [PW-1:0]        prod_r;
  logic [DENW-1:0]      den_r;
  logic [LW-1:0]        i_r;
  logic [1:0]           j_r;
  logic                 neg_r;
  logic [COLW-1:0]      res_r;
  logic                 res_out_r;

  logic                 out_valid_r;
  logic [COLW-1:0]      out_col_r;
  logic                 out_outside_r;

  // query front end
  logic signed [DW-1:0] p_ext, s_ext, e_ext, len_s, d_c;
  logic                 rev, outside_c, in_acc, is_query;
  logic [NW-1:0]        n_c;

  // shared units
  logic           div_start, div_done;
  logic [UW-1:0]  div_dividend, div_divisor, div_rem;
  logic [STW-1:0] div_steps;
  logic [CW-1:0]  div_quot;
  logic [MAW-1:0] mul_a;
  logic [MBW-1:0] mul_b;
  logic [PW-1:0]  mul_p;
  logic           out_load;

  // datapath helpers
  logic [LW:0]     dv, rr, mm, dn;
  logic [DW-1:0]   absd;
  logic [OFFW-1:0] o_clamp, eff_c, diff_c;
  logic [LW-1:0]   seg_c;
  logic [LW:0]     sum_c;
  logic            last_k, dlt;
  logic [7:0]      c0, c1, dc_abs, v_c;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign is_query  = in_req_type == grc_pkg::REQ_QUERY;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grad_start_r  <= CW'(grc_pkg::GRAD_START_RST);
      grad_end_r    <= CW'(grc_pkg::GRAD_END_RST);
      spread_r      <= grc_pkg::SPREAD_PAD;
      stop_count_r  <= 5'(grc_pkg::STOP_COUNT_RST);
      line_length_r <= 16'(grc_pkg::LINE_LENGTH_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        grc_pkg::REG_GRAD_START:  grad_start_r  <= cfg_data[CW-1:0];
        grc_pkg::REG_GRAD_END:    grad_end_r    <= cfg_data[CW-1:0];
        grc_pkg::REG_SPREAD_MODE: spread_r      <= cfg_data[1:0];
        grc_pkg::REG_STOP_COUNT:  stop_count_r  <= cfg_data[4:0];
        grc_pkg::REG_LINE_LENGTH: line_length_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !is_query && 32'(in_stop_index) < MAX_STOPS) begin
      mem[SW'(in_stop_index)] <= {in_stop_offset, in_stop_red, in_stop_green,
                                  in_stop_blue, in_stop_alpha};
    end
    rd_q_r <= mem[k_r];
  end

  always_comb begin
    p_ext     = DW'(in_position);
    s_ext     = DW'(grad_start_r);
    e_ext     = DW'(grad_end_r);
    rev       = e_ext < s_ext;
    len_s     = rev ? (s_ext - e_ext) : (e_ext - s_ext);
    d_c       = rev ? (s_ext - p_ext) : (p_ext - s_ext);
    outside_c = in_position[CW-1] ||
                (XW'($unsigned(in_position)) >= XW'(line_length_r));
    if (stop_count_r == 5'd0) begin
      n_c = NW'(1);
    end else if (32'(stop_count_r) > MAX_STOPS) begin
      n_c = NW'(MAX_STOPS);
    end else begin
      n_c = NW'(stop_count_r);
    end
  end

  always_comb begin
    dv   = (spread_r == grc_pkg::SPREAD_REFLECT) ? {len_r, 1'b0} : {1'b0, len_r};
    absd = d_r[DW-1] ? DW'(-d_r) : DW'(d_r);
    rr   = div_rem[LW:0];
    mm   = (d_r[DW-1] && rr != '0) ? (dv - rr) : rr;
    dn   = (spread_r == grc_pkg::SPREAD_REFLECT && mm >= {1'b0, len_r}) ?
           (dv - (LW+1)'(1) - mm) : mm;
    o_clamp = (rd_q_r[MW-1 -: OFFW] > grc_pkg::OFFSET_ONE) ? grc_pkg::OFFSET_ONE
                                                            : rd_q_r[MW-1 -: OFFW];
    eff_c   = (o_clamp < prev_eff_r) ? prev_eff_r : o_clamp;
    diff_c  = eff_c - prev_eff_r;
    seg_c   = prod_r[16 +: LW];
    sum_c   = {1'b0, pos_r} + {1'b0, seg_c};
    dlt     = {1'b0, d_r[LW-1:0]} < sum_c;
    last_k  = k_r == SW'(n_r - NW'(1));
    c0      = grc_pkg::chan(prev_col_r, j_r);
    c1      = grc_pkg::chan(cur_col_r, j_r);
    dc_abs  = (c1 < c0) ? (c0 - c1) : (c1 - c0);
    v_c     = neg_r ? (c0 - div_quot[7:0] - 8'(|div_rem)) : (c0 + div_quot[7:0]);
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  grc_div #(.UW(UW), .QW(CW), .STW(STW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      grc_pkg::ST_IDLE: begin
        if (in_acc && is_query) begin
          if (outside_c) begin
            state_nxt = grc_pkg::ST_DONE;
          end else if (len_s == '0) begin
            state_nxt = grc_pkg::ST_FETCH;
          end else if (spread_r == grc_pkg::SPREAD_REFLECT ||
                       spread_r == grc_pkg::SPREAD_REPEAT) begin
            state_nxt = grc_pkg::ST_MOD;
          end else begin
            state_nxt = grc_pkg::ST_CLASS;
          end
        end
      end
      grc_pkg::ST_MOD:  state_nxt = grc_pkg::ST_MODW;
      grc_pkg::ST_MODW: if (div_done) state_nxt = grc_pkg::ST_CLASS;
      grc_pkg::ST_CLASS: begin
        if (d_r[DW-1] || $unsigned(d_r) >= DW'(len_r)) begin
          state_nxt = grc_pkg::ST_FETCH;
        end else begin
          state_nxt = grc_pkg::ST_RD;
        end
      end
      grc_pkg::ST_FETCH:   state_nxt = grc_pkg::ST_FETCH_D;
      grc_pkg::ST_FETCH_D: state_nxt = grc_pkg::ST_DONE;
      grc_pkg::ST_RD:      state_nxt = grc_pkg::ST_EFF;
      grc_pkg::ST_EFF:     state_nxt = grc_pkg::ST_SEG;
      grc_pkg::ST_SEG: begin
        if (dlt) begin
          state_nxt = (k_r == '0) ? grc_pkg::ST_DONE : grc_pkg::ST_IMUL;
        end else if (last_k) begin
          state_nxt = grc_pkg::ST_DONE;
        end else begin
          state_nxt = grc_pkg::ST_RD;
        end
      end
      grc_pkg::ST_IMUL: state_nxt = grc_pkg::ST_IDIV;
      grc_pkg::ST_IDIV: state_nxt = grc_pkg::ST_IDIVW;
      grc_pkg::ST_IDIVW: begin
        if (div_done) begin
          state_nxt = (j_r == 2'd3) ? grc_pkg::ST_DONE : grc_pkg::ST_IMUL;
        end
      end
      grc_pkg::ST_DONE: if (out_load) state_nxt = grc_pkg::ST_IDLE;
      default: state_nxt = grc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = state_r != grc_pkg::ST_IDLE;
    out_load     = state_r == grc_pkg::ST_DONE && (!out_valid_r || !out_stall);
    div_start    = state_r == grc_pkg::ST_MOD || state_r == grc_pkg::ST_IDIV;
    div_dividend = UW'({prod_r[NUMW-1:0], 16'h0000});
    div_divisor  = UW'({den_r, 7'b0000000});
    div_steps    = STW'(8);
    mul_a        = MAW'(diff_c);
    mul_b        = len_r;
    if (state_r == grc_pkg::ST_MOD) begin
      div_dividend = UW'(absd);
      div_divisor  = UW'({dv, {(CW-1){1'b0}}});
      div_steps    = STW'(CW);
    end
    if (state_r == grc_pkg::ST_IMUL) begin
      mul_a = MAW'(i_r);
      mul_b = MBW'(dc_abs);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= grc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (out_valid_r && out_stall) || out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_col_r     <= res_r;
      out_outside_r <= res_out_r;
    end
    unique case (state_r)
      grc_pkg::ST_IDLE: begin
        len_r     <= LW'($unsigned(len_s));
        d_r       <= d_c;
        n_r       <= n_c;
        k_r       <= SW'(n_c - NW'(1));
        res_r     <= '0;
        res_out_r <= outside_c;
      end
      grc_pkg::ST_MODW: if (div_done) d_r <= $signed(DW'(dn[LW-1:0]));
      grc_pkg::ST_CLASS: begin
        k_r        <= d_r[DW-1] ? '0 :
                      ($unsigned(d_r) >= DW'(len_r)) ? SW'(n_r - NW'(1)) : '0;
        pos_r      <= '0;
        prev_eff_r <= '0;
      end
      grc_pkg::ST_FETCH_D: res_r <= rd_q_r[COLW-1:0];
      grc_pkg::ST_EFF: begin
        prod_r     <= mul_p;
        prev_eff_r <= eff_c;
        prev_col_r <= cur_col_r;
        cur_col_r  <= rd_q_r[COLW-1:0];
      end
      grc_pkg::ST_SEG: begin
        den_r <= prod_r[DENW-1:0];
        i_r   <= d_r[LW-1:0] - pos_r;
        j_r   <= 2'd0;
        pos_r <= sum_c[LW-1:0];
        k_r   <= k_r + SW'(!dlt && !last_k);
        res_r <= cur_col_r;
      end
      grc_pkg::ST_IMUL: begin
        prod_r <= mul_p;
        neg_r  <= c1 < c0;
      end
      grc_pkg::ST_IDIVW: begin
        if (div_done) begin
          res_r[8 * (3 - 32'(j_r)) +: 8] <= v_c;
          j_r <= j_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_red     = out_col_r[31:24];
  assign out_green   = out_col_r[23:16];
  assign out_blue    = out_col_r[15:8];
  assign out_alpha   = out_col_r[7:0];
  assign out_outside = out_outside_r;

`include "gradient_ramp_color_core_assert.svh"

  `GRC_AST_IMP(a_outside_black, out_valid && out_outside, out_col_r == '0)
  `GRC_AST_IMP(a_div_done_waited, div_done, state_r == grc_pkg::ST_MODW || state_r == grc_pkg::ST_IDIVW)
  `GRC_AST_NXT(a_done_loads_out, out_load, out_valid_r && state_r == grc_pkg::ST_IDLE)

endmodule
